@@ rtl/core/line_sphere_intersection_macros.svh @@
// Assertion macros used by the checker file of the line and sphere intersection block.
`ifndef LINE_SPHERE_INTERSECTION_MACROS_SVH
`define LINE_SPHERE_INTERSECTION_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LSI_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define LSI_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked around reset.
`define LSI_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lsi_pkg.sv @@
// Shared constants and types for the line and sphere intersection block.
`timescale 1ns / 1ps

package lsi_pkg;

    localparam int RADIUS_WIDTH = 31;
    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 31'd65536;
    localparam int RADIUS_FRAC = 16;
    localparam int MUL_CHUNK = 16;

    typedef enum logic [1:0] {
        KIND_MISS       = 2'd0,
        KIND_TANGENT    = 2'd1,
        KIND_TWO_HITS   = 2'd2,
        KIND_DEGENERATE = 2'd3
    } hit_kind_t;

endpackage

@@ rtl/core/lsi_delay.sv @@
// Enabled shift line that keeps side data aligned with a pipelined unit.
`timescale 1ns / 1ps

module lsi_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] dly_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule

@@ rtl/core/lsi_mul.sv @@
// Pipelined signed multiplier that adds one chunk of the second operand per stage.
`timescale 1ns / 1ps

module lsi_mul #(
    parameter int AW = 34,
    parameter int BW = 34,
    parameter int CH = 16
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NCH = (BW + CH - 1) / CH;
    localparam int BX  = NCH * CH;
    localparam int MW  = AW + BX;
    localparam int TW  = AW + CH + 1;

    logic signed [BX-1:0] bext;
    logic signed [AW-1:0] a_reg   [NCH];
    logic signed [BX-1:0] b_reg   [NCH];
    logic signed [MW-1:0] acc_reg [NCH];

    assign bext = BX'(b);

    genvar k;
    for (k = 0; k < NCH; k++) begin : g_stage
        logic signed [AW-1:0] a_in;
        logic signed [BX-1:0] b_in;
        logic signed [MW-1:0] acc_in;
        logic signed [TW-1:0] digit;
        logic signed [TW-1:0] term;
        logic signed [MW-1:0] acc_next;

        if (k == 0) begin : g_first
            assign a_in   = a;
            assign b_in   = bext;
            assign acc_in = '0;
        end else begin : g_rest
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        // The top chunk carries the sign, the lower chunks are unsigned digits.
        if (k == NCH - 1) begin : g_top
            assign digit = TW'($signed(b_in[k*CH +: CH]));
        end else begin : g_low
            assign digit = $signed(TW'(b_in[k*CH +: CH]));
        end

        assign term     = TW'(a_in) * digit;
        assign acc_next = acc_in + (MW'(term) <<< (k * CH));

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[k]   <= a_in;
                b_reg[k]   <= b_in;
                acc_reg[k] <= acc_next;
            end
        end
    end

    assign p = $signed(acc_reg[NCH-1][AW+BW-1:0]);

endmodule

@@ rtl/core/lsi_isqrt.sv @@
// Pipelined floor square root that settles one result bit per stage.
`timescale 1ns / 1ps

module lsi_isqrt #(
    parameter int VW = 138
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [VW-1:0]            v,
    output logic [(VW+1)/2-1:0]      root
);

    localparam int RTW  = (VW + 1) / 2;
    localparam int VX   = 2 * RTW;
    localparam int REMW = RTW + 3;

    logic [VX-1:0]   v_reg    [RTW];
    logic [REMW-1:0] rem_reg  [RTW];
    logic [RTW-1:0]  root_reg [RTW];

    genvar k;
    for (k = 0; k < RTW; k++) begin : g_stage
        logic [VX-1:0]   v_in;
        logic [REMW-1:0] rem_in;
        logic [RTW-1:0]  root_in;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            fit;

        if (k == 0) begin : g_first
            assign v_in    = VX'(v);
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign rem_sh = {rem_in[REMW-3:0], v_in[VX-1 -: 2]};
        assign trial  = REMW'({root_in, 2'b01});
        assign fit    = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k]    <= {v_in[VX-3:0], 2'b00};
                rem_reg[k]  <= fit ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[RTW-2:0], fit};
            end
        end
    end

    assign root = root_reg[RTW-1];

endmodule

@@ rtl/core/lsi_div.sv @@
// Pipelined restoring divider with a bounded quotient and an overflow flag.
`timescale 1ns / 1ps

module lsi_div #(
    parameter int NUMW = 108,
    parameter int DENW = 69,
    parameter int QW   = 33
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic [QW-1:0]   quo,
    output logic            ovf
);

    localparam int CMPW = (NUMW > DENW) ? NUMW : DENW;
    localparam int RW   = DENW + 1;

    logic [RW-1:0]   rem_reg [QW+1];
    logic [QW-1:0]   lo_reg  [QW+1];
    logic [QW-1:0]   quo_reg [QW+1];
    logic [DENW-1:0] den_reg [QW+1];
    logic            ovf_reg [QW+1];

    // The quotient cannot fit when the high part of the numerator reaches the divisor.
    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0] <= (CMPW'(num >> QW) >= CMPW'(den));
            rem_reg[0] <= RW'(num >> QW);
            lo_reg[0]  <= num[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
        end
    end

    genvar j;
    for (j = 1; j <= QW; j++) begin : g_stage
        logic [RW-1:0] rem_sh;
        logic          fit;

        assign rem_sh = {rem_reg[j-1][RW-2:0], lo_reg[j-1][QW-1]};
        assign fit    = (rem_sh >= RW'(den_reg[j-1]));

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= fit ? (rem_sh - RW'(den_reg[j-1])) : rem_sh;
                lo_reg[j]  <= lo_reg[j-1] << 1;
                quo_reg[j] <= {quo_reg[j-1][QW-2:0], fit};
                den_reg[j] <= den_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

@@ rtl/core/line_sphere_intersection.sv @@
// Top level of the pipelined line and sphere intersection block.
//
//  Port group     Direction  Handshake         Payload
//  s_*            in         s_valid/s_ready   start, end, center, viewer xyz
//  m_*            out        m_valid/m_ready   point xyz, hit_kind
//  cfg_*          in         cfg_wr_en         sphere radius
//
// One item enters per cycle while no result waits on m_ready; the square root settles
// one bit per stage and the three dividers one quotient bit per stage.
// The whole pipeline advances together and holds while a result waits on m_ready.
// Reset clears the valid bits and loads the radius with 1.0.
`timescale 1ns / 1ps

module line_sphere_intersection
    import lsi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_start_z,
    input  logic signed [COORD_WIDTH-1:0] s_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_end_y,
    input  logic signed [COORD_WIDTH-1:0] s_end_z,
    input  logic signed [COORD_WIDTH-1:0] s_center_x,
    input  logic signed [COORD_WIDTH-1:0] s_center_y,
    input  logic signed [COORD_WIDTH-1:0] s_center_z,
    input  logic signed [COORD_WIDTH-1:0] s_viewer_x,
    input  logic signed [COORD_WIDTH-1:0] s_viewer_y,
    input  logic signed [COORD_WIDTH-1:0] s_viewer_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_point_x,
    output logic signed [COORD_WIDTH-1:0] m_point_y,
    output logic signed [COORD_WIDTH-1:0] m_point_z,
    output logic [1:0]                    m_hit_kind,
    input  logic                          cfg_wr_en,
    input  logic [RADIUS_WIDTH-1:0]       cfg_wr_data
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PPW  = 2 * DW;
    localparam int PW   = PPW + 2;
    localparam int RUP  = (FRAC_BITS > RADIUS_FRAC) ? (FRAC_BITS - RADIUS_FRAC) : 0;
    localparam int RDN  = (FRAC_BITS < RADIUS_FRAC) ? (RADIUS_FRAC - FRAC_BITS) : 0;
    localparam int RW   = RADIUS_WIDTH + RUP;
    localparam int SQW  = 2 * RW;
    localparam int CW   = ((PW > SQW) ? PW : SQW) + 2;
    localparam int L1   = (CW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int VW   = PW + CW;
    localparam int QSW  = VW + 1;
    localparam int RTW  = (VW + 1) / 2;
    localparam int NW   = ((PW > RTW) ? PW : RTW) + 2;
    localparam int L2   = (NW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MGW  = DW + NW;
    localparam int XW   = MGW + 2;
    localparam int DENW = PW + 1;
    localparam int QTW  = W + 1;
    localparam int LD   = QTW + 1;
    localparam int SUMW = W + 3;
    localparam int LAT  = 3 + L1 + 1 + RTW + 1 + L2 + 1 + LD + 1;

    typedef logic signed [W-1:0]    crd_t;
    typedef logic signed [DW-1:0]   dif_t;
    typedef logic signed [PPW-1:0]  prd_t;
    typedef logic signed [PW-1:0]   dot_t;
    typedef logic signed [CW-1:0]   cq_t;
    typedef logic signed [QSW-1:0]  qs_t;
    typedef logic signed [NW-1:0]   nt_t;
    typedef logic signed [MGW-1:0]  mg_t;
    typedef logic signed [SUMW-1:0] sw_t;

    typedef struct packed {
        crd_t [2:0] s;
        dif_t [2:0] d;
        dot_t       a;
        dot_t       h;
        logic       dg_neg;
        logic       a_zero;
    } geo_t;

    typedef struct packed {
        geo_t geo;
        logic q_neg;
        logic q_zero;
    } root_side_t;

    typedef struct packed {
        crd_t [2:0] s;
        dot_t       a;
        hit_kind_t  kind;
        logic       a_zero;
    } proj_side_t;

    typedef struct packed {
        crd_t [2:0] s;
        logic [2:0] neg;
        hit_kind_t  kind;
        logic       a_zero;
    } div_side_t;

    localparam crd_t CRD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam crd_t CRD_MIN = {1'b1, {(W-1){1'b0}}};

    logic                    en;
    logic [LAT-1:0]          valid_reg;
    logic [RADIUS_WIDTH-1:0] radius_reg;
    logic [RW-1:0]           radius_scaled;
    logic [SQW-1:0]          rsq_reg;

    crd_t [2:0] in_s, in_e, in_c, in_v;
    crd_t [2:0] s1_s_reg;
    dif_t [2:0] s1_d_reg, s1_f_reg, s1_g_reg;
    crd_t [2:0] s2_s_reg;
    dif_t [2:0] s2_d_reg;
    prd_t [2:0] s2_dd_reg, s2_df_reg, s2_ff_reg, s2_dg_reg;

    dot_t a_sum, h_sum, ff_sum, dg_sum;
    geo_t geo3_reg;
    cq_t  c3_reg;

    logic signed [PW+CW-1:0] hh_prod, ac_prod;
    geo_t        geo_dly;
    qs_t         q_reg;
    geo_t        geoq_reg;
    root_side_t  rs_in, rs_dly;
    logic [VW-1:0]  sqrt_in;
    logic [RTW-1:0] root;

    nt_t        nb, a_n, rt, n_next;
    hit_kind_t  kind_next;
    nt_t        n_reg;
    dif_t [2:0] dn_reg;
    proj_side_t ps_reg, ps_dly;

    mg_t             prod_w [3];
    logic [XW-1:0]   num_reg [3];
    logic [DENW-1:0] den_reg;
    div_side_t       ds_reg, ds_dly;
    logic [QTW-1:0]  quo_w [3];
    logic            ovf_w [3];

    crd_t [2:0] point_reg;
    logic [1:0] kind_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[LAT-1];

    assign in_s = {s_start_z, s_start_y, s_start_x};
    assign in_e = {s_end_z, s_end_y, s_end_x};
    assign in_c = {s_center_z, s_center_y, s_center_x};
    assign in_v = {s_viewer_z, s_viewer_y, s_viewer_x};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            radius_reg <= RADIUS_RESET;
        end else begin
            if (en) begin
                valid_reg <= {valid_reg[LAT-2:0], s_valid};
            end
            if (cfg_wr_en) begin
                radius_reg <= cfg_wr_data;
            end
        end
    end

    assign radius_scaled = RW'((RW'(radius_reg) << RUP) >> RDN);

    always_ff @(posedge aclk) begin
        rsq_reg <= SQW'(radius_scaled) * SQW'(radius_scaled);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_s_reg[i] <= in_s[i];
                s1_d_reg[i] <= dif_t'(in_e[i]) - dif_t'(in_s[i]);
                s1_f_reg[i] <= dif_t'(in_s[i]) - dif_t'(in_c[i]);
                s1_g_reg[i] <= dif_t'(in_c[i]) - dif_t'(in_v[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_s_reg <= s1_s_reg;
            s2_d_reg <= s1_d_reg;
            for (int i = 0; i < 3; i++) begin
                s2_dd_reg[i] <= prd_t'(s1_d_reg[i]) * prd_t'(s1_d_reg[i]);
                s2_df_reg[i] <= prd_t'(s1_d_reg[i]) * prd_t'(s1_f_reg[i]);
                s2_ff_reg[i] <= prd_t'(s1_f_reg[i]) * prd_t'(s1_f_reg[i]);
                s2_dg_reg[i] <= prd_t'(s1_d_reg[i]) * prd_t'(s1_g_reg[i]);
            end
        end
    end

    always_comb begin
        a_sum  = dot_t'(s2_dd_reg[0]) + dot_t'(s2_dd_reg[1]) + dot_t'(s2_dd_reg[2]);
        h_sum  = dot_t'(s2_df_reg[0]) + dot_t'(s2_df_reg[1]) + dot_t'(s2_df_reg[2]);
        ff_sum = dot_t'(s2_ff_reg[0]) + dot_t'(s2_ff_reg[1]) + dot_t'(s2_ff_reg[2]);
        dg_sum = dot_t'(s2_dg_reg[0]) + dot_t'(s2_dg_reg[1]) + dot_t'(s2_dg_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo3_reg.s      <= s2_s_reg;
            geo3_reg.d      <= s2_d_reg;
            geo3_reg.a      <= a_sum;
            geo3_reg.h      <= h_sum;
            geo3_reg.dg_neg <= dg_sum[PW-1];
            geo3_reg.a_zero <= (a_sum == '0);
            c3_reg          <= cq_t'(ff_sum) - $signed(CW'(rsq_reg));
        end
    end

    lsi_mul #(.AW(PW), .BW(CW), .CH(MUL_CHUNK)) u_mul_hh (
        .aclk (aclk),
        .en   (en),
        .a    ($signed(geo3_reg.h)),
        .b    (cq_t'($signed(geo3_reg.h))),
        .p    (hh_prod)
    );

    lsi_mul #(.AW(PW), .BW(CW), .CH(MUL_CHUNK)) u_mul_ac (
        .aclk (aclk),
        .en   (en),
        .a    ($signed(geo3_reg.a)),
        .b    (c3_reg),
        .p    (ac_prod)
    );

    lsi_delay #(.WIDTH($bits(geo_t)), .DEPTH(L1)) u_dly_geo (
        .aclk (aclk),
        .en   (en),
        .din  (geo3_reg),
        .dout (geo_dly)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg    <= qs_t'(hh_prod) - qs_t'(ac_prod);
            geoq_reg <= geo_dly;
        end
    end

    always_comb begin
        rs_in.geo    = geoq_reg;
        rs_in.q_neg  = q_reg[QSW-1];
        rs_in.q_zero = (q_reg == '0);
        sqrt_in      = q_reg[QSW-1] ? '0 : q_reg[VW-1:0];
    end

    lsi_isqrt #(.VW(VW)) u_isqrt (
        .aclk (aclk),
        .en   (en),
        .v    (sqrt_in),
        .root (root)
    );

    lsi_delay #(.WIDTH($bits(root_side_t)), .DEPTH(RTW)) u_dly_root (
        .aclk (aclk),
        .en   (en),
        .din  (rs_in),
        .dout (rs_dly)
    );

    // A miss projects the center onto the segment, clamped to its two ends.
    always_comb begin
        nb  = -nt_t'($signed(rs_dly.geo.h));
        a_n = nt_t'($signed(rs_dly.geo.a));
        rt  = nt_t'($signed({1'b0, root}));
        if (rs_dly.q_neg) begin
            kind_next = KIND_MISS;
            if (nb < 0) begin
                n_next = '0;
            end else if (nb >= a_n) begin
                n_next = a_n;
            end else begin
                n_next = nb;
            end
        end else if (rs_dly.q_zero) begin
            kind_next = KIND_TANGENT;
            n_next    = nb;
        end else begin
            kind_next = KIND_TWO_HITS;
            n_next    = rs_dly.geo.dg_neg ? (nb + rt) : (nb - rt);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg         <= n_next;
            dn_reg        <= rs_dly.geo.d;
            ps_reg.s      <= rs_dly.geo.s;
            ps_reg.a      <= rs_dly.geo.a;
            ps_reg.kind   <= kind_next;
            ps_reg.a_zero <= rs_dly.geo.a_zero;
        end
    end

    lsi_delay #(.WIDTH($bits(proj_side_t)), .DEPTH(L2)) u_dly_proj (
        .aclk (aclk),
        .en   (en),
        .din  (ps_reg),
        .dout (ps_dly)
    );

    genvar gi;
    for (gi = 0; gi < 3; gi++) begin : g_axis
        lsi_mul #(.AW(DW), .BW(NW), .CH(MUL_CHUNK)) u_mul_dn (
            .aclk (aclk),
            .en   (en),
            .a    ($signed(dn_reg[gi])),
            .b    (n_reg),
            .p    (prod_w[gi])
        );

        lsi_div #(.NUMW(XW), .DENW(DENW), .QW(QTW)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num_reg[gi]),
            .den  (den_reg),
            .quo  (quo_w[gi]),
            .ovf  (ovf_w[gi])
        );
    end

    // Round to nearest with halves away from zero: (2|p| + a) / 2a on the magnitude.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= (XW'(prod_w[i][MGW-1] ? -prod_w[i] : prod_w[i]) << 1)
                              + XW'($unsigned(ps_dly.a));
                ds_reg.neg[i] <= prod_w[i][MGW-1];
            end
            den_reg       <= DENW'($unsigned(ps_dly.a)) << 1;
            ds_reg.s      <= ps_dly.s;
            ds_reg.kind   <= ps_dly.kind;
            ds_reg.a_zero <= ps_dly.a_zero;
        end
    end

    lsi_delay #(.WIDTH($bits(div_side_t)), .DEPTH(LD)) u_dly_div (
        .aclk (aclk),
        .en   (en),
        .din  (ds_reg),
        .dout (ds_dly)
    );

    always_ff @(posedge aclk) begin
        sw_t sum;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sum = ds_dly.neg[i]
                    ? (sw_t'($signed(ds_dly.s[i])) - sw_t'($signed({1'b0, quo_w[i]})))
                    : (sw_t'($signed(ds_dly.s[i])) + sw_t'($signed({1'b0, quo_w[i]})));
                if (ds_dly.a_zero) begin
                    point_reg[i] <= ds_dly.s[i];
                end else if (ovf_w[i]) begin
                    point_reg[i] <= ds_dly.neg[i] ? CRD_MIN : CRD_MAX;
                end else if (sum > sw_t'(CRD_MAX)) begin
                    point_reg[i] <= CRD_MAX;
                end else if (sum < sw_t'(CRD_MIN)) begin
                    point_reg[i] <= CRD_MIN;
                end else begin
                    point_reg[i] <= sum[W-1:0];
                end
            end
            kind_reg <= ds_dly.a_zero ? KIND_DEGENERATE : ds_dly.kind;
        end
    end

    assign m_point_x  = point_reg[0];
    assign m_point_y  = point_reg[1];
    assign m_point_z  = point_reg[2];
    assign m_hit_kind = kind_reg;

endmodule

@@ rtl/core/line_sphere_intersection_checker.sv @@
// Port-level assertions for the line and sphere intersection block and their binding.
`timescale 1ns / 1ps
`include "line_sphere_intersection_macros.svh"

module line_sphere_intersection_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [COORD_WIDTH-1:0] m_point_x,
    input logic signed [COORD_WIDTH-1:0] m_point_y,
    input logic signed [COORD_WIDTH-1:0] m_point_z,
    input logic [1:0]                    m_hit_kind
);

    `LSI_ASSERT_NXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_point_x) && $stable(m_point_y) && $stable(m_point_z) && $stable(m_hit_kind), "stalled result item changed")
    `LSI_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready, "input taken while the result item is stalled")
    `LSI_ASSERT_IMP(a_free_takes_input, aclk, aresetn, !m_valid || m_ready, s_ready, "input refused while the pipeline can advance")
    `LSI_ASSERT_RST(a_reset_empties, aclk, !aresetn, !m_valid, "result item present right after reset")

endmodule

bind line_sphere_intersection line_sphere_intersection_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_point_x  (m_point_x),
    .m_point_y  (m_point_y),
    .m_point_z  (m_point_z),
    .m_hit_kind (m_hit_kind)
);

@@ test/tb_line_sphere_intersection.sv @@
// Self-checking testbench for the pipelined line and sphere intersection block.
`timescale 1ns / 1ps

module tb_line_sphere_intersection;
    import lsi_pkg::*;

    localparam int CW = 32;
    localparam int ONE = 65536;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT = 20000;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [CW-1:0] query_t [12];

    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
        hit_kind_t kind;
    } hit_point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_start_x = '0, s_start_y = '0, s_start_z = '0;
    logic signed [CW-1:0] s_end_x = '0, s_end_y = '0, s_end_z = '0;
    logic signed [CW-1:0] s_center_x = '0, s_center_y = '0, s_center_z = '0;
    logic signed [CW-1:0] s_viewer_x = '0, s_viewer_y = '0, s_viewer_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CW-1:0] m_point_x, m_point_y, m_point_z;
    logic [1:0] m_hit_kind;
    logic cfg_wr_en = 1'b0;
    logic [RADIUS_WIDTH-1:0] cfg_wr_data = '0;

    hit_point_t expected_points[$];
    logic [RADIUS_WIDTH-1:0] radius_now = RADIUS_RESET;
    int idle_pct = 19;
    int errors = 0;
    int quiet_cycles = 0;

    line_sphere_intersection DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y), .s_start_z(s_start_z),
        .s_end_x(s_end_x), .s_end_y(s_end_y), .s_end_z(s_end_z),
        .s_center_x(s_center_x), .s_center_y(s_center_y), .s_center_z(s_center_z),
        .s_viewer_x(s_viewer_x), .s_viewer_y(s_viewer_y), .s_viewer_z(s_viewer_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_x(m_point_x), .m_point_y(m_point_y), .m_point_z(m_point_z),
        .m_hit_kind(m_hit_kind),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    function automatic wide_t floor_sqrt(input wide_t v);
        wide_t res;
        wide_t cand;
        wide_t one;
        res = '0;
        one = 1;
        for (int b = 103; b >= 0; b--) begin
            cand = res | (one << b);
            if (cand * cand <= v) res = cand;
        end
        return res;
    endfunction

    function automatic hit_point_t predict_hit(input query_t qy, input logic [30:0] rad);
        wide_t s[3], d[3], f[3], g[3];
        wide_t a, h, cc, disc, nb, n, r, dg, prod, mag, quo, sum;
        wide_t hi, lo;
        logic signed [CW-1:0] pt[3];
        hit_point_t res;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        r = {225'd0, rad};
        a = 0; h = 0; cc = 0; dg = 0;
        for (int i = 0; i < 3; i++) begin
            s[i] = qy[i];
            d[i] = wide_t'(qy[3 + i]) - s[i];
            f[i] = s[i] - wide_t'(qy[6 + i]);
            g[i] = wide_t'(qy[6 + i]) - wide_t'(qy[9 + i]);
            a += d[i] * d[i];
            h += d[i] * f[i];
            cc += f[i] * f[i];
            dg += d[i] * g[i];
        end
        if (a == 0) begin
            res.px = qy[0]; res.py = qy[1]; res.pz = qy[2];
            res.kind = KIND_DEGENERATE;
            return res;
        end
        cc -= r * r;
        disc = h * h - a * cc;
        nb = -h;
        if (disc < 0) begin
            res.kind = KIND_MISS;
            n = (nb < 0) ? 0 : ((nb >= a) ? a : nb);
        end else if (disc == 0) begin
            res.kind = KIND_TANGENT;
            n = nb;
        end else begin
            res.kind = KIND_TWO_HITS;
            n = (dg < 0) ? nb + floor_sqrt(disc) : nb - floor_sqrt(disc);
        end
        for (int i = 0; i < 3; i++) begin
            prod = d[i] * n;
            mag = (prod < 0) ? -prod : prod;
            quo = (2 * mag + a) / (2 * a);
            sum = s[i] + ((prod < 0) ? -quo : quo);
            if (sum > hi) sum = hi;
            else if (sum < lo) sum = lo;
            pt[i] = sum[CW-1:0];
        end
        res.px = pt[0]; res.py = pt[1]; res.pz = pt[2];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic send_query(input query_t qy);
        hit_point_t want;
        want = predict_hit(qy, radius_now);
        while ($urandom_range(99) < idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        {s_start_x, s_start_y, s_start_z} = {qy[0], qy[1], qy[2]};
        {s_end_x, s_end_y, s_end_z} = {qy[3], qy[4], qy[5]};
        {s_center_x, s_center_y, s_center_z} = {qy[6], qy[7], qy[8]};
        {s_viewer_x, s_viewer_y, s_viewer_z} = {qy[9], qy[10], qy[11]};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_points = {expected_points, want};
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [RADIUS_WIDTH-1:0] rad);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = rad;
        radius_now = rad;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic query_t make_query(input int sx, sy, sz, ex, ey, ez,
                                          cx, cy, cz, vx, vy, vz);
        query_t qy;
        qy = '{sx, sy, sz, ex, ey, ez, cx, cy, cz, vx, vy, vz};
        return qy;
    endfunction

    function automatic logic signed [CW-1:0] near_coord(input int base, input int span);
        return base + $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic query_t random_query(input int span);
        query_t qy;
        int cb[3];
        for (int i = 0; i < 3; i++) cb[i] = $signed($urandom_range(1 << 23)) - (1 << 22);
        for (int i = 0; i < 12; i++) begin
            if (span == 0) qy[i] = $urandom;
            else if (i >= 9) qy[i] = near_coord(cb[i % 3], 4 * span);
            else qy[i] = near_coord(cb[i % 3], span);
        end
        if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) qy[3 + i] = qy[i];
        return qy;
    endfunction

    task automatic test_directed();
        int mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        send_query(make_query(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0, 0));
        send_query(make_query(-2 * ONE, ONE, 0, 2 * ONE, ONE, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(-2 * ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 0, 9 * ONE, 0, 0));
        send_query(make_query(-2 * ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 0, -9 * ONE, 0, 0));
        send_query(make_query(-2 * ONE, 0, ONE / 3, 2 * ONE, ONE / 7, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(2 * ONE, 5 * ONE, 0, 4 * ONE, 5 * ONE, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(-4 * ONE, 5 * ONE, 0, -2 * ONE, 5 * ONE, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(-2 * ONE, 5 * ONE, 0, 2 * ONE, 5 * ONE, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_query(make_query(mn, mn, mn, mx, mx, mx, 0, 0, 0, mn, mn, mn));
        send_query(make_query(mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx));
        send_query(make_query(mx, mn, mx, mn, mx, mn, mx, mx, mn, mn, mn, mx));
        send_query(make_query(mx - ONE, 0, 0, mx, 0, 0, 0, 0, 0, mx, 0, 0));
        send_query(make_query(-1, -1, -1, 1, 1, 1, 0, 0, 0, -1, 0, 1));
    endtask

    task automatic test_radius_extremes();
        write_radius('0);
        send_query(make_query(-2 * ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 0, 9 * ONE, 0, 0));
        send_query(make_query(-2 * ONE, ONE, 0, 2 * ONE, ONE, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(-2, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        write_radius({RADIUS_WIDTH{1'b1}});
        send_query(make_query(-2 * ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 0, 9 * ONE, 0, 0));
        send_query(make_query(-2 * ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 0, -9 * ONE, 0, 0));
        send_query(make_query(0, 0, 0, ONE, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0));
        send_query(make_query(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_geometry();
        int span;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) write_radius(RADIUS_RESET);
            else write_radius(RADIUS_WIDTH'($urandom_range(1 << 22)));
            idle_pct = (phase == 2) ? 0 : 19;
            for (int k = 0; k < 270; k++) begin
                span = ($urandom_range(9) == 0) ? 0 : (1 << $urandom_range(22, 12));
                send_query(random_query(span));
            end
        end
        idle_pct = 19;
    endtask

    always @(negedge aclk) m_ready = ($urandom_range(99) >= idle_pct);

    always @(posedge aclk) begin
        hit_point_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("result with no pending expectation");
                end else begin
                    want = expected_points.pop_front();
                    if (m_point_x !== want.px)
                        report_mismatch($sformatf("point_x %0d, want %0d", m_point_x, want.px));
                    if (m_point_y !== want.py)
                        report_mismatch($sformatf("point_y %0d, want %0d", m_point_y, want.py));
                    if (m_point_z !== want.pz)
                        report_mismatch($sformatf("point_z %0d, want %0d", m_point_z, want.pz));
                    if (m_hit_kind !== want.kind)
                        report_mismatch($sformatf("hit_kind %0d, want %0d", m_hit_kind, want.kind));
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_radius_extremes();
        test_random_geometry();
        wait_drained();
        if (errors == 0 && expected_points.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
